>>> design/bmmd_pkg.sv
// ----------------------------------------------------------------------------
// bmmd_pkg
// Shared sizes, target codes, region codes and the decode record of the
// banked memory map decoder.
// ----------------------------------------------------------------------------
package bmmd_pkg;

    // Storage sizes.
    localparam int WRAM_BANK_BYTES = 4096;
    localparam int WRAM_BANKS      = 8;
    localparam int VRAM_BANK_BYTES = 8192;
    localparam int SPRITE_BYTES    = 160;
    localparam int HRAM_BYTES      = 127;

    // Derived widths.
    localparam int WRAM_SW_BANKS = WRAM_BANKS - 1;
    localparam int WRAM_OFF_W    = $clog2(WRAM_BANK_BYTES);
    localparam int WRAM_BANK_W   = $clog2(WRAM_BANKS);
    localparam int WRAM_AW       = WRAM_BANK_W + WRAM_OFF_W;
    localparam int VRAM_OFF_W    = $clog2(VRAM_BANK_BYTES);
    localparam int VRAM_AW       = VRAM_OFF_W + 1;
    localparam int SPRITE_AW     = $clog2(SPRITE_BYTES);
    localparam int HRAM_AW       = $clog2(HRAM_BYTES);

    // Fixed register addresses.
    localparam logic [15:0] ADDR_IRQ_FLAGS = 16'hFF0F;
    localparam logic [15:0] ADDR_SPEED     = 16'hFF4D;
    localparam logic [15:0] ADDR_BANK_SEL  = 16'hFF70;
    localparam logic [15:0] ADDR_IRQ_EN    = 16'hFFFF;

    // Target codes seen by the bus.
    localparam logic [3:0] TGT_INTERNAL = 4'd0;
    localparam logic [3:0] TGT_CART     = 4'd1;
    localparam logic [3:0] TGT_JOYPAD   = 4'd2;
    localparam logic [3:0] TGT_SERIAL   = 4'd3;
    localparam logic [3:0] TGT_DIVIDER  = 4'd4;
    localparam logic [3:0] TGT_TIMER    = 4'd5;
    localparam logic [3:0] TGT_SOUND    = 4'd6;
    localparam logic [3:0] TGT_DISPLAY  = 4'd7;
    localparam logic [3:0] TGT_UNMAPPED = 4'd8;

    // Internal storage regions.
    localparam logic [3:0] RGN_NONE     = 4'd0;
    localparam logic [3:0] RGN_VRAM     = 4'd1;
    localparam logic [3:0] RGN_WRAM     = 4'd2;
    localparam logic [3:0] RGN_SPRITE   = 4'd3;
    localparam logic [3:0] RGN_HRAM     = 4'd4;
    localparam logic [3:0] RGN_IRQ_FLAG = 4'd5;
    localparam logic [3:0] RGN_IRQ_EN   = 4'd6;
    localparam logic [3:0] RGN_SPEED    = 4'd7;
    localparam logic [3:0] RGN_BANK_SEL = 4'd8;

    typedef logic [3:0] t_target;
    typedef logic [3:0] t_region;

    // One decoded access.
    typedef struct packed {
        t_target                target;
        t_region                region;
        logic [WRAM_AW-1:0]     wram_idx;
        logic [VRAM_AW-1:0]     vram_idx;
        logic [SPRITE_AW-1:0]   sprite_idx;
        logic [HRAM_AW-1:0]     hram_idx;
    } t_decode;

endpackage

>>> design/bmmd_req_if.sv
// ----------------------------------------------------------------------------
// bmmd_req_if
// Channel that carries one bus access item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bmmd_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        vram_bank;

    modport source (output valid, command, address, write_data, vram_bank, input ready);
    modport sink   (input valid, command, address, write_data, vram_bank, output ready);
endinterface

>>> design/bmmd_rsp_if.sv
// ----------------------------------------------------------------------------
// bmmd_rsp_if
// Channel that carries one decode result item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bmmd_rsp_if
    import bmmd_pkg::*;
;
    logic        valid;
    logic        ready;
    t_target     target;
    logic [7:0]  read_data;
    logic [15:0] device_address;
    logic [7:0]  device_data;
    logic        device_write;

    modport source (output valid, target, read_data, device_address, device_data,
                    device_write, input ready);
    modport sink   (input valid, target, read_data, device_address, device_data,
                    device_write, output ready);
endinterface

>>> design/bmmd_decode.sv
// ----------------------------------------------------------------------------
// bmmd_decode
// Address decoder: maps a bus address to a target code, an internal region
// and the entry index inside that region's store.
// ----------------------------------------------------------------------------
module bmmd_decode
    import bmmd_pkg::*;
(
    input  logic [15:0] i_address,
    input  logic        i_vram_bank,
    input  logic [2:0]  i_bank_sel,
    output t_decode     o_dec
);

    // Bank for one bank-select value: zero selects bank one, and banks past
    // the built ones fold back onto banks one and up. Only evaluated on
    // constants while the table below is built.
    function automatic logic [3:0] fold_bank(input int sel);
        int b;
        b = (sel == 0) ? 1 : sel;
        if (b >= WRAM_BANKS) begin
            b = 1 + ((b - 1) % WRAM_SW_BANKS);
        end
        return 4'(b);
    endfunction

    localparam logic [3:0] BANK_FOLD [0:7] = '{
        fold_bank(0), fold_bank(1), fold_bank(2), fold_bank(3),
        fold_bank(4), fold_bank(5), fold_bank(6), fold_bank(7)
    };

    logic [3:0] bank_num;

    // Switchable bank from the folding table.
    always_comb begin
        bank_num = BANK_FOLD[i_bank_sel];
        // The lower window of work RAM and its mirror always use bank zero.
        if (!i_address[12]) begin
            bank_num = 4'd0;
        end
    end

    // Entry indexes and map decode.
    always_comb begin
        // Each region keeps only the low address bits it needs.
        o_dec.wram_idx   = {bank_num[WRAM_BANK_W-1:0], i_address[WRAM_OFF_W-1:0]};
        o_dec.vram_idx   = {i_vram_bank, i_address[VRAM_OFF_W-1:0]};
        o_dec.sprite_idx = i_address[SPRITE_AW-1:0];
        o_dec.hram_idx   = i_address[HRAM_AW-1:0];

        o_dec.target = TGT_INTERNAL;
        o_dec.region = RGN_NONE;
        case (i_address) inside
            [16'h0000:16'h7FFF], [16'hA000:16'hBFFF]: begin
                o_dec.target = TGT_CART;
            end
            [16'h8000:16'h9FFF]: begin
                o_dec.region = RGN_VRAM;
            end
            [16'hC000:16'hFDFF]: begin
                o_dec.region = RGN_WRAM;
            end
            [16'hFE00:16'hFE9F]: begin
                o_dec.region = RGN_SPRITE;
            end
            ADDR_IRQ_FLAGS: begin
                o_dec.region = RGN_IRQ_FLAG;
            end
            ADDR_SPEED: begin
                o_dec.region = RGN_SPEED;
            end
            ADDR_BANK_SEL: begin
                o_dec.region = RGN_BANK_SEL;
            end
            [16'hFF80:16'hFFFE]: begin
                o_dec.region = RGN_HRAM;
            end
            ADDR_IRQ_EN: begin
                o_dec.region = RGN_IRQ_EN;
            end
            16'hFF00: begin
                o_dec.target = TGT_JOYPAD;
            end
            16'hFF01, 16'hFF02: begin
                o_dec.target = TGT_SERIAL;
            end
            16'hFF04: begin
                o_dec.target = TGT_DIVIDER;
            end
            [16'hFF05:16'hFF07]: begin
                o_dec.target = TGT_TIMER;
            end
            [16'hFF10:16'hFF14], [16'hFF16:16'hFF1E], [16'hFF20:16'hFF26],
            [16'hFF30:16'hFF3F]: begin
                o_dec.target = TGT_SOUND;
            end
            [16'hFF40:16'hFF4B], 16'hFF4F, [16'hFF51:16'hFF55],
            [16'hFF68:16'hFF6B]: begin
                o_dec.target = TGT_DISPLAY;
            end
            default: begin
                // Unusable area and unlisted I/O addresses.
                o_dec.target = TGT_UNMAPPED;
            end
        endcase
    end

endmodule

>>> design/banked_memory_map_decoder.sv
// ----------------------------------------------------------------------------
// banked_memory_map_decoder
// Decodes one byte bus access per item against the 64 KiB map, serves the
// internal RAMs and registers, and forwards device ranges with a target code.
// ----------------------------------------------------------------------------
//  Channel  Port   Direction  Carries
//  -------  -----  ---------  ---------------------------------------------
//  request  i_req  sink       command, address, write_data, vram_bank
//  result   o_rsp  source     target, read_data, device_address/data/write
//
// One item is accepted per cycle unless the result side stalls; its result
// appears in the next cycle, from the registered read of the selected RAM.
// A request is taken whenever the result register is empty or being taken,
// so a stalled result holds the request side for as long as it waits.
// Reset clears the control registers (bank select to one); RAM contents stay
// undefined until written and need no clearing pass.
// ----------------------------------------------------------------------------
module banked_memory_map_decoder
    import bmmd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    bmmd_req_if.sink      i_req,
    bmmd_rsp_if.source    o_rsp
);

    // Storage.
    logic [7:0] wram   [0:WRAM_BANKS*WRAM_BANK_BYTES-1];
    logic [7:0] vram   [0:2*VRAM_BANK_BYTES-1];
    logic [7:0] sprite [0:SPRITE_BYTES-1];
    logic [7:0] hram   [0:HRAM_BYTES-1];

    logic [7:0] r_irq_flags;
    logic [7:0] r_irq_en;
    logic [7:0] r_speed;
    logic [2:0] r_bank_sel;

    // Result stage.
    logic        r_out_valid;
    t_target     r_target;
    t_region     r_region;
    logic [15:0] r_dev_addr;
    logic [7:0]  r_dev_data;
    logic        r_dev_write;
    logic [7:0]  r_reg_data;
    logic [7:0]  r_wram_q;
    logic [7:0]  r_vram_q;
    logic [7:0]  r_sprite_q;
    logic [7:0]  r_hram_q;

    t_decode dec;
    logic    accept;
    logic    is_wr;
    logic    is_rd;
    logic    fwd;
    logic [7:0] reg_rd;

    bmmd_decode u_decode (
        .i_address   (i_req.address),
        .i_vram_bank (i_req.vram_bank),
        .i_bank_sel  (r_bank_sel),
        .o_dec       (dec)
    );

    // Handshake.
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign is_wr       = accept && i_req.command;
    assign is_rd       = accept && !i_req.command;
    assign fwd         = (dec.target != TGT_INTERNAL) && (dec.target != TGT_UNMAPPED);

    // Work RAM port.
    always_ff @(posedge i_clk) begin
        if (dec.region == RGN_WRAM) begin
            if (is_wr) begin
                wram[dec.wram_idx] <= i_req.write_data;
            end else if (is_rd) begin
                r_wram_q <= wram[dec.wram_idx];
            end
        end
    end

    // Video RAM port.
    always_ff @(posedge i_clk) begin
        if (dec.region == RGN_VRAM) begin
            if (is_wr) begin
                vram[dec.vram_idx] <= i_req.write_data;
            end else if (is_rd) begin
                r_vram_q <= vram[dec.vram_idx];
            end
        end
    end

    // Sprite table port.
    always_ff @(posedge i_clk) begin
        if (dec.region == RGN_SPRITE) begin
            if (is_wr) begin
                sprite[dec.sprite_idx] <= i_req.write_data;
            end else if (is_rd) begin
                r_sprite_q <= sprite[dec.sprite_idx];
            end
        end
    end

    // High RAM port.
    always_ff @(posedge i_clk) begin
        if (dec.region == RGN_HRAM) begin
            if (is_wr) begin
                hram[dec.hram_idx] <= i_req.write_data;
            end else if (is_rd) begin
                r_hram_q <= hram[dec.hram_idx];
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_irq_flags <= 8'h00;
            r_irq_en    <= 8'h00;
            r_speed     <= 8'h00;
            r_bank_sel  <= 3'd1;
        end else if (is_wr) begin
            case (dec.region)
                RGN_IRQ_FLAG: r_irq_flags <= i_req.write_data;
                RGN_IRQ_EN:   r_irq_en    <= i_req.write_data;
                RGN_SPEED:    r_speed     <= i_req.write_data;
                RGN_BANK_SEL: r_bank_sel  <= i_req.write_data[2:0];
                default: begin
                end
            endcase
        end
    end

    // Register read value for the accepted item.
    always_comb begin
        case (dec.region)
            RGN_IRQ_FLAG: reg_rd = r_irq_flags;
            RGN_IRQ_EN:   reg_rd = r_irq_en;
            RGN_SPEED:    reg_rd = r_speed;
            RGN_BANK_SEL: reg_rd = {5'd0, r_bank_sel};
            default:      reg_rd = 8'h00;
        endcase
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload; a write to an internal store reads back as zero.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_target    <= dec.target;
            r_region    <= i_req.command ? RGN_NONE : dec.region;
            r_reg_data  <= reg_rd;
            r_dev_addr  <= fwd ? i_req.address : 16'h0000;
            r_dev_data  <= (fwd && i_req.command) ? i_req.write_data : 8'h00;
            r_dev_write <= fwd && i_req.command;
        end
    end

    // Output read byte from the store that served the item.
    always_comb begin
        if (r_target == TGT_UNMAPPED) begin
            o_rsp.read_data = 8'hFF;
        end else begin
            case (r_region)
                RGN_WRAM:     o_rsp.read_data = r_wram_q;
                RGN_VRAM:     o_rsp.read_data = r_vram_q;
                RGN_SPRITE:   o_rsp.read_data = r_sprite_q;
                RGN_HRAM:     o_rsp.read_data = r_hram_q;
                RGN_IRQ_FLAG, RGN_IRQ_EN, RGN_SPEED, RGN_BANK_SEL:
                              o_rsp.read_data = r_reg_data;
                default:      o_rsp.read_data = 8'h00;
            endcase
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.target         = r_target;
    assign o_rsp.device_address = r_dev_addr;
    assign o_rsp.device_data    = r_dev_data;
    assign o_rsp.device_write   = r_dev_write;

endmodule

>>> tb/sv/bmmd_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmmd_tb_pkg
// Bus map predictor and result scoreboard for the banked memory map decoder
// testbench. It mirrors the internal RAMs and registers and keeps the
// expected decode of every accepted access in order.
// ----------------------------------------------------------------------------
package bmmd_tb_pkg;
    import bmmd_pkg::*;

    // Access direction codes on the request channel.
    localparam logic ACC_READ  = 1'b0;
    localparam logic ACC_WRITE = 1'b1;

    // Only the first few mismatches are printed in full.
    localparam int MISMATCH_PRINT_MAX = 10;

    // One result item as seen on the result channel.
    typedef struct packed {
        t_target     target;
        logic [7:0]  read_data;
        logic [15:0] device_address;
        logic [7:0]  device_data;
        logic        device_write;
    } bus_result_t;

    class bus_map_scoreboard;
        // Mirrored storage, with a flag per byte that marks it as written.
        logic [7:0] wram [WRAM_BANKS*WRAM_BANK_BYTES];
        bit         wram_set [WRAM_BANKS*WRAM_BANK_BYTES];
        logic [7:0] vram [2*VRAM_BANK_BYTES];
        bit         vram_set [2*VRAM_BANK_BYTES];
        logic [7:0] sprite [SPRITE_BYTES];
        bit         sprite_set [SPRITE_BYTES];
        logic [7:0] hram [HRAM_BYTES];
        bit         hram_set [HRAM_BYTES];
        logic [7:0] irq_flags;
        logic [7:0] irq_enable;
        logic [7:0] speed_reg;
        logic [2:0] bank_sel;

        bus_result_t expected_results[$];
        int          mismatches;
        int          results_checked;

        function new();
            irq_flags       = 8'h00;
            irq_enable      = 8'h00;
            speed_reg       = 8'h00;
            bank_sel        = 3'd1;
            mismatches      = 0;
            results_checked = 0;
        endfunction

        // Bank seen at 0xD000: zero selects bank one, and a bank past the
        // built ones folds back onto the switchable banks.
        function int active_bank();
            int b;
            b = int'(bank_sel);
            if (b == 0)
                b = 1;
            if (b >= WRAM_BANKS)
                b = 1 + ((b - 1) % WRAM_SW_BANKS);
            return b;
        endfunction

        // Internal store and byte index that an address reaches.
        function void locate(logic [15:0] a, logic vb, output t_region rgn, output int slot);
            int off;
            rgn  = RGN_NONE;
            slot = 0;
            if (a >= 16'h8000 && a <= 16'h9FFF) begin
                rgn  = RGN_VRAM;
                slot = (int'(a) - 'h8000) + int'(vb) * VRAM_BANK_BYTES;
            end else if (a >= 16'hC000 && a <= 16'hFDFF) begin
                // The echo range folds onto 0xC000.
                rgn  = RGN_WRAM;
                off  = (int'(a) - 'hC000) & 'h1FFF;
                slot = ((off < WRAM_BANK_BYTES) ? 0 : active_bank()) * WRAM_BANK_BYTES
                       + (off % WRAM_BANK_BYTES);
            end else if (a >= 16'hFE00 && a <= 16'hFE9F) begin
                rgn  = RGN_SPRITE;
                slot = int'(a) - 'hFE00;
            end else if (a == ADDR_IRQ_FLAGS) begin
                rgn = RGN_IRQ_FLAG;
            end else if (a == ADDR_SPEED) begin
                rgn = RGN_SPEED;
            end else if (a == ADDR_BANK_SEL) begin
                rgn = RGN_BANK_SEL;
            end else if (a >= 16'hFF80 && a <= 16'hFFFE) begin
                rgn  = RGN_HRAM;
                slot = int'(a) - 'hFF80;
            end else if (a == ADDR_IRQ_EN) begin
                rgn = RGN_IRQ_EN;
            end
        endfunction

        // Target of an address that no internal store serves.
        function t_target device_target(logic [15:0] a);
            if (a < 16'h8000 || (a >= 16'hA000 && a <= 16'hBFFF)) return TGT_CART;
            if (a == 16'hFF00) return TGT_JOYPAD;
            if (a == 16'hFF01 || a == 16'hFF02) return TGT_SERIAL;
            if (a == 16'hFF04) return TGT_DIVIDER;
            if (a >= 16'hFF05 && a <= 16'hFF07) return TGT_TIMER;
            if ((a >= 16'hFF10 && a <= 16'hFF14) || (a >= 16'hFF16 && a <= 16'hFF1E) ||
                (a >= 16'hFF20 && a <= 16'hFF26) || (a >= 16'hFF30 && a <= 16'hFF3F))
                return TGT_SOUND;
            if ((a >= 16'hFF40 && a <= 16'hFF4B) || a == 16'hFF4F ||
                (a >= 16'hFF51 && a <= 16'hFF55) || (a >= 16'hFF68 && a <= 16'hFF6B))
                return TGT_DISPLAY;
            return TGT_UNMAPPED;
        endfunction

        // True unless the access would read a RAM byte never written.
        function bit read_is_defined(logic [15:0] a, logic vb);
            t_region rgn;
            int      slot;
            locate(a, vb, rgn, slot);
            case (rgn)
                RGN_VRAM:   return vram_set[slot];
                RGN_WRAM:   return wram_set[slot];
                RGN_SPRITE: return sprite_set[slot];
                RGN_HRAM:   return hram_set[slot];
                default:    return 1'b1;
            endcase
        endfunction

        // Applies one access to the mirrored state and returns its decode.
        function bus_result_t decode_access(logic wr, logic [15:0] a, logic [7:0] d,
                                            logic vb);
            t_region     rgn;
            int          slot;
            bus_result_t r;
            r        = '0;
            r.target = TGT_INTERNAL;
            locate(a, vb, rgn, slot);
            case (rgn)
                RGN_VRAM: begin
                    if (wr == ACC_WRITE) begin
                        vram[slot]     = d;
                        vram_set[slot] = 1'b1;
                    end else begin
                        r.read_data = vram[slot];
                    end
                end
                RGN_WRAM: begin
                    if (wr == ACC_WRITE) begin
                        wram[slot]     = d;
                        wram_set[slot] = 1'b1;
                    end else begin
                        r.read_data = wram[slot];
                    end
                end
                RGN_SPRITE: begin
                    if (wr == ACC_WRITE) begin
                        sprite[slot]     = d;
                        sprite_set[slot] = 1'b1;
                    end else begin
                        r.read_data = sprite[slot];
                    end
                end
                RGN_HRAM: begin
                    if (wr == ACC_WRITE) begin
                        hram[slot]     = d;
                        hram_set[slot] = 1'b1;
                    end else begin
                        r.read_data = hram[slot];
                    end
                end
                RGN_IRQ_FLAG: begin
                    if (wr == ACC_WRITE) irq_flags = d;
                    else r.read_data = irq_flags;
                end
                RGN_IRQ_EN: begin
                    if (wr == ACC_WRITE) irq_enable = d;
                    else r.read_data = irq_enable;
                end
                RGN_SPEED: begin
                    if (wr == ACC_WRITE) speed_reg = d;
                    else r.read_data = speed_reg;
                end
                RGN_BANK_SEL: begin
                    // Only the low three bits are kept.
                    if (wr == ACC_WRITE) bank_sel = d[2:0];
                    else r.read_data = {5'b0, bank_sel};
                end
                default: begin
                    r.target = device_target(a);
                end
            endcase

            // Forwarded accesses carry the address and the write byte.
            if (r.target == TGT_UNMAPPED) begin
                r.read_data = 8'hFF;
            end else if (r.target != TGT_INTERNAL) begin
                r.device_address = a;
                r.device_data    = (wr == ACC_WRITE) ? d : 8'h00;
                r.device_write   = wr;
            end
            return r;
        endfunction

        // Called for every accepted request item.
        function void note_access(logic wr, logic [15:0] a, logic [7:0] d, logic vb);
            expected_results.push_back(decode_access(wr, a, d, vb));
        endfunction

        // Called for every accepted result item.
        function void check_result(bus_result_t got);
            bus_result_t exp;
            results_checked++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MISMATCH_PRINT_MAX)
                    $display("result %0d arrived with no access waiting: target %0d",
                             results_checked, got.target);
                return;
            end
            exp = expected_results.pop_front();
            if (got.target !== exp.target || got.read_data !== exp.read_data ||
                got.device_address !== exp.device_address ||
                got.device_data !== exp.device_data ||
                got.device_write !== exp.device_write) begin
                mismatches++;
                if (mismatches <= MISMATCH_PRINT_MAX) begin
                    $display(
                        "result %0d expected: tgt %0d rd %02h addr %04h data %02h wr %0b",
                        results_checked, exp.target, exp.read_data, exp.device_address,
                        exp.device_data, exp.device_write);
                    $display(
                        "result %0d actual:   tgt %0d rd %02h addr %04h data %02h wr %0b",
                        results_checked, got.target, got.read_data, got.device_address,
                        got.device_data, got.device_write);
                end
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

endpackage

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives bus accesses into the banked memory map decoder and checks every
// decode against a mirrored copy of the map. A short directed pass covers
// each region, register and corner of the map, then random accesses with
// random idling on both channels, a long result stall and drain pauses.
// ----------------------------------------------------------------------------
module testbench;
    import bmmd_pkg::*;
    import bmmd_tb_pkg::*;

    localparam int RANDOM_ACCESSES = 1120;
    localparam int MAX_IDLE        = 13;
    localparam int LONG_HOLD_AT    = 400;
    localparam int LONG_HOLD       = 300;
    localparam int STALL_LIMIT     = 3000;
    localparam int RECENT_MAX      = 48;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bmmd_req_if req_ch ();
    bmmd_rsp_if rsp_ch ();

    banked_memory_map_decoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    bus_map_scoreboard sb;
    int  results_seen = 0;
    int  idle_cycles  = 0;
    bit  tx_calm      = 1'b0;
    bit  rx_calm      = 1'b0;
    bit  long_hold_done = 1'b0;

    // Recently written {address, vram bank} pairs, reused as read targets.
    logic [16:0] recent_stores[$];

    // Clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Sample both channels and feed the scoreboard.
    always @(posedge i_clk) begin : monitor
        bus_result_t got;
        bit          moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (rsp_ch.valid && rsp_ch.ready) begin
                got.target         = rsp_ch.target;
                got.read_data      = rsp_ch.read_data;
                got.device_address = rsp_ch.device_address;
                got.device_data    = rsp_ch.device_data;
                got.device_write   = rsp_ch.device_write;
                sb.check_result(got);
                results_seen++;
                moved = 1'b1;
            end
            if (req_ch.valid && req_ch.ready) begin
                sb.note_access(req_ch.command, req_ch.address, req_ch.write_data,
                               req_ch.vram_bank);
                moved = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    // Give up when nothing moves for too long.
    initial begin : watchdog
        wait (idle_cycles >= STALL_LIMIT);
        $display("banked_memory_map_decoder regression: fail");
        $finish;
    end

    // Result side: random hold-off per item, calm stretches, one long stall.
    initial begin : result_sink
        int hold;
        rsp_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 49) == 0)
                rx_calm = !rx_calm;
            if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
                hold           = LONG_HOLD;
                long_hold_done = 1'b1;
            end else begin
                hold = rx_calm ? 0 : $urandom_range(0, MAX_IDLE);
            end
            if (hold > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (hold) @(negedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_ch.valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // Offer one access after a random gap and hold it until it is taken.
    task automatic send_access(logic wr, logic [15:0] addr, logic [7:0] data, logic vb);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.command    <= wr;
        req_ch.address    <= addr;
        req_ch.write_data <= data;
        req_ch.vram_bank  <= vb;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stop offering until every expected result has come back.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
    endtask

    // Address drawn by region, with narrow windows so reads find written bytes.
    function automatic logic [15:0] random_address();
        int r;
        bit narrow;
        r      = $urandom_range(0, 99);
        narrow = 1'($urandom_range(0, 1));
        if (r < 8)  return 16'($urandom_range(0, 'h7FFF));
        if (r < 12) return 16'($urandom_range('hA000, 'hBFFF));
        if (r < 24)
            return 16'('h8000 + (narrow ? $urandom_range(0, 63) : $urandom_range(0, 'h1FFF)));
        if (r < 46) begin
            if (narrow)
                return 16'('hC000 + $urandom_range(0, 3) * 'h1000 + $urandom_range(0, 63));
            return 16'('hC000 + $urandom_range(0, 'h3DFF));
        end
        if (r < 54) return 16'('hFE00 + $urandom_range(0, SPRITE_BYTES - 1));
        if (r < 58) return 16'($urandom_range('hFEA0, 'hFEFF));
        if (r < 66) begin
            case ($urandom_range(0, 2))
                0:       return ADDR_IRQ_FLAGS;
                1:       return ADDR_SPEED;
                default: return ADDR_BANK_SEL;
            endcase
        end
        if (r < 80) return 16'($urandom_range('hFF00, 'hFF7F));
        if (r < 90)
            return 16'('hFF80 + (narrow ? $urandom_range(0, 15) : $urandom_range(0, 126)));
        if (r < 94) return ADDR_IRQ_EN;
        return 16'($urandom_range(0, 'hFFFF));
    endfunction

    // One random access; a read that would hit an unwritten byte becomes a write.
    task automatic send_random_access();
        logic        wr;
        logic [15:0] addr;
        logic [7:0]  data;
        logic        vb;
        wr   = $urandom_range(0, 1) ? ACC_WRITE : ACC_READ;
        data = 8'($urandom_range(0, 255));
        vb   = 1'($urandom_range(0, 1));
        if (wr == ACC_READ && recent_stores.size() > 0 && $urandom_range(0, 99) < 40)
            {addr, vb} = recent_stores[$urandom_range(0, recent_stores.size() - 1)];
        else
            addr = random_address();
        if (wr == ACC_READ && !sb.read_is_defined(addr, vb))
            wr = ACC_WRITE;
        if (wr == ACC_WRITE) begin
            recent_stores.push_back({addr, vb});
            if (recent_stores.size() > RECENT_MAX)
                void'(recent_stores.pop_front());
        end
        send_access(wr, addr, data, vb);
    endtask

    // Main sequence.
    initial begin : stimulus
        int sent;
        int chunk_len;
        int chunk_no;
        sb = new();
        req_ch.valid      = 1'b0;
        req_ch.command    = ACC_READ;
        req_ch.address    = 16'h0000;
        req_ch.write_data = 8'h00;
        req_ch.vram_bank  = 1'b0;
        i_rst_n           = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Register reset values, then full-byte register write and read back.
        send_access(ACC_READ,  ADDR_BANK_SEL,  8'h00, 1'b0);
        send_access(ACC_READ,  ADDR_IRQ_FLAGS, 8'h00, 1'b1);
        send_access(ACC_WRITE, ADDR_IRQ_EN,    8'hA5, 1'b0);
        send_access(ACC_READ,  ADDR_IRQ_EN,    8'h00, 1'b0);
        send_access(ACC_WRITE, ADDR_SPEED,     8'hFF, 1'b1);
        send_access(ACC_READ,  ADDR_SPEED,     8'h00, 1'b0);
        // Cartridge range edges.
        send_access(ACC_READ,  16'h7FFF, 8'h00, 1'b1);
        send_access(ACC_WRITE, 16'hBFFF, 8'h5A, 1'b0);
        // Video RAM in both banks.
        send_access(ACC_WRITE, 16'h8000, 8'h11, 1'b0);
        send_access(ACC_WRITE, 16'h9FFF, 8'h22, 1'b1);
        send_access(ACC_READ,  16'h9FFF, 8'h00, 1'b1);
        // Work RAM bank zero through its echo.
        send_access(ACC_WRITE, 16'hC000, 8'h33, 1'b0);
        send_access(ACC_READ,  16'hE000, 8'h00, 1'b0);
        // Bank select zero still maps bank one; top of the echo range.
        send_access(ACC_WRITE, ADDR_BANK_SEL, 8'h00, 1'b0);
        send_access(ACC_WRITE, 16'hFDFF, 8'h44, 1'b0);
        send_access(ACC_READ,  16'hDDFF, 8'h00, 1'b0);
        // Bank select keeps only three bits.
        send_access(ACC_WRITE, ADDR_BANK_SEL, 8'hFF, 1'b0);
        send_access(ACC_READ,  ADDR_BANK_SEL, 8'h00, 1'b0);
        // Sprite table end, unusable range and an unlisted I/O address.
        send_access(ACC_WRITE, 16'hFE9F, 8'h66, 1'b1);
        send_access(ACC_READ,  16'hFE9F, 8'h00, 1'b1);
        send_access(ACC_READ,  16'hFEA0, 8'h00, 1'b0);
        send_access(ACC_WRITE, 16'hFF56, 8'h99, 1'b0);
        // High RAM and every forwarded device.
        send_access(ACC_WRITE, 16'hFF80, 8'h77, 1'b0);
        send_access(ACC_READ,  16'hFF80, 8'h00, 1'b0);
        send_access(ACC_READ,  16'hFF00, 8'h00, 1'b0);
        send_access(ACC_WRITE, 16'hFF02, 8'h81, 1'b0);
        send_access(ACC_READ,  16'hFF04, 8'h00, 1'b0);
        send_access(ACC_WRITE, 16'hFF05, 8'h0C, 1'b0);
        send_access(ACC_READ,  16'hFF26, 8'h00, 1'b0);
        send_access(ACC_WRITE, 16'hFF4F, 8'hC3, 1'b1);
        wait_drained();

        // Random accesses in chunks; some chunks start only once drained.
        sent     = 0;
        chunk_no = 0;
        while (sent < RANDOM_ACCESSES) begin
            chunk_len = $urandom_range(16, 96);
            tx_calm   = ($urandom_range(0, 3) == 0);
            if (chunk_no % 5 == 4)
                wait_drained();
            repeat (chunk_len) begin
                send_random_access();
                sent++;
            end
            chunk_no++;
        end

        // Drain, then wait on for any stray result.
        wait_drained();
        repeat (8) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("banked_memory_map_decoder regression: pass");
        else
            $display("banked_memory_map_decoder regression: fail");
        $finish;
    end

endmodule

>>> banked_memory_map_decoder.f
design/bmmd_pkg.sv
design/bmmd_req_if.sv
design/bmmd_rsp_if.sv
design/bmmd_decode.sv
design/banked_memory_map_decoder.sv
tb/sv/bmmd_tb_pkg.sv
tb/sv/testbench.sv
